FILE: hdl/kgp_pkg.sv
// Package: widths, beat structs and helpers for the k-mer group presence row block.
`timescale 1ns / 1ps

package kgp_pkg;

  localparam int unsigned KmerBits      = 62;
  localparam int unsigned BankBits      = 6;
  localparam int unsigned AbundanceBits = 32;
  localparam int unsigned MaxBanks      = 64;
  localparam int unsigned TotalBits     = 32;
  localparam int unsigned CfgBits       = 7;

  // Output queue: four rows, a record is taken while two slots are free.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Saturation value two for the group sum and record count.
  localparam logic [1:0] SatTwo = 2'd2;

  typedef struct packed {
    logic [KmerBits-1:0]      kmer_value;
    logic [BankBits-1:0]      bank_index;
    logic [AbundanceBits-1:0] abundance_value;
    logic                     final_record;
  } kgp_in_t;

  typedef struct packed {
    logic [KmerBits-1:0]  row_kmer;
    logic [MaxBanks-1:0]  presence_mask;
    logic                 row_kept;
    logic                 row_shared;
    logic [TotalBits-1:0] kept_total;
    logic [TotalBits-1:0] shared_total;
    logic                 row_last;
  } kgp_out_t;

  function automatic logic [TotalBits-1:0] sat_inc(input logic [TotalBits-1:0] v,
                                                   input logic en);
    logic [TotalBits-1:0] r;
    r = v;
    if (en && (v != {TotalBits{1'b1}})) r = v + TotalBits'(1);
    return r;
  endfunction

endpackage

FILE: hdl/kmer_group_presence_row.sv
// Top level: groups a key-sorted k-mer record stream into presence rows.
//
//  channel | signals                       | direction | payload
//  --------+-------------------------------+-----------+--------------------------
//  in      | in_valid_i / in_ready_o       | sink      | in_data_i  (kgp_in_t)
//  out     | out_valid_o / out_ready_i     | source    | out_data_o (kgp_out_t)
//  cfg     | cfg_we_i                      | sink      | cfg_data_i (bank count)
//
// One record is taken per cycle while in_ready_o is high; it updates the group registers and pushes zero,
// one or two finished rows into a four-entry output queue in the same edge.
// A row can leave the queue in the cycle after its record is taken, at the earliest.
// in_ready_o is high while the queue holds at most two rows, so a stalled output
// stops intake after two or three beats that push rows; beats that only join a
// group keep flowing. Queue occupancy sets the rate.
// Reset clears the group state, totals and queue, and sets the bank count to 64.
`timescale 1ns / 1ps

module kmer_group_presence_row
  import kgp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kgp_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kgp_out_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgBits-1:0] cfg_data_i
);

  localparam logic [MaxBanks-1:0] MaskOne  = MaxBanks'(1);
  localparam logic [CfgBits-1:0]  BankLim  = CfgBits'(MaxBanks);
  localparam logic [QueueCntW-1:0] CntLimit = QueueCntW'(QueueDepth - 2);

  // Configuration and group state.
  logic [CfgBits-1:0]   bank_count_q;
  logic [KmerBits-1:0]  cur_kmer_q, cur_kmer_d;
  logic                 open_q, open_d;
  logic [MaxBanks-1:0]  mask_q, mask_d;
  logic [1:0]           sum_q, sum_d;
  logic [1:0]           cnt_q, cnt_d;
  logic [TotalBits-1:0] kept_q, kept_d;
  logic [TotalBits-1:0] shared_q, shared_d;

  // Output queue.
  kgp_out_t             queue_q [QueueDepth];
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueueCntW-1:0] qcnt_q, qcnt_d;

  logic                 in_fire;
  logic                 out_fire;
  logic                 differ;
  logic                 fresh;
  logic [CfgBits-1:0]   limit;
  logic                 in_range;
  logic                 abund_nz;
  logic                 abund_big;
  logic [MaxBanks-1:0]  mask_base, mask_new;
  logic [1:0]           sum_base, sum_new;
  logic [1:0]           cnt_base, cnt_new;
  logic                 kept0, shared0, kept1, shared1;
  logic [TotalBits-1:0] kept1_tot, shared1_tot, kept2_tot, shared2_tot;
  kgp_out_t             row0, row1;
  logic                 push_a, push_b;
  kgp_out_t             data_a;
  logic [1:0]           push_n;
  logic [QueuePtrW-1:0] wr_ptr_b;

  assign in_ready_o  = (qcnt_q <= CntLimit);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (qcnt_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign out_data_o  = queue_q[rd_ptr_q];

  // Record processing: close the open group on a key change, fold the record in, close it after a final record.
  always_comb begin
    differ    = open_q && (in_data_i.kmer_value != cur_kmer_q);
    fresh     = !open_q || differ;
    limit     = (bank_count_q > BankLim) ? BankLim : bank_count_q;
    in_range  = ({1'b0, in_data_i.bank_index} < limit);
    abund_nz  = |in_data_i.abundance_value;
    abund_big = |in_data_i.abundance_value[AbundanceBits-1:1];

    mask_base = fresh ? '0 : mask_q;
    sum_base  = fresh ? '0 : sum_q;
    cnt_base  = fresh ? '0 : cnt_q;

    cnt_new  = (cnt_base == SatTwo) ? SatTwo : cnt_base + 2'd1;
    mask_new = mask_base;
    sum_new  = sum_base;
    if (in_range) begin
      if (abund_nz) mask_new = mask_base | (MaskOne << in_data_i.bank_index);
      if (abund_big || (sum_base == SatTwo) ||
          (sum_base == 2'd1 && in_data_i.abundance_value[0])) begin
        sum_new = SatTwo;
      end else begin
        sum_new = sum_base + {1'b0, in_data_i.abundance_value[0]};
      end
    end

    kept0       = (sum_q == SatTwo);
    shared0     = (cnt_q == SatTwo);
    kept1_tot   = sat_inc(kept_q, differ && kept0);
    shared1_tot = sat_inc(shared_q, differ && shared0);
    kept1       = (sum_new == SatTwo);
    shared1     = (cnt_new == SatTwo);
    kept2_tot   = sat_inc(kept1_tot, kept1);
    shared2_tot = sat_inc(shared1_tot, shared1);

    row0.row_kmer      = cur_kmer_q;
    row0.presence_mask = mask_q;
    row0.row_kept      = kept0;
    row0.row_shared    = shared0;
    row0.kept_total    = kept1_tot;
    row0.shared_total  = shared1_tot;
    row0.row_last      = 1'b0;

    row1.row_kmer      = in_data_i.kmer_value;
    row1.presence_mask = mask_new;
    row1.row_kept      = kept1;
    row1.row_shared    = shared1;
    row1.kept_total    = kept2_tot;
    row1.shared_total  = shared2_tot;
    row1.row_last      = 1'b1;

    cur_kmer_d = cur_kmer_q;
    open_d     = open_q;
    mask_d     = mask_q;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    kept_d     = kept_q;
    shared_d   = shared_q;
    if (in_fire) begin
      cur_kmer_d = in_data_i.kmer_value;
      if (in_data_i.final_record) begin
        // Final beat: emit the group holding this record and close it.
        open_d   = 1'b0;
        mask_d   = '0;
        sum_d    = '0;
        cnt_d    = '0;
        kept_d   = kept2_tot;
        shared_d = shared2_tot;
      end else begin
        open_d   = 1'b1;
        mask_d   = mask_new;
        sum_d    = sum_new;
        cnt_d    = cnt_new;
        kept_d   = kept1_tot;
        shared_d = shared1_tot;
      end
    end
  end

  // Queue push: the closed group goes first, the final row after it.
  always_comb begin
    push_a   = in_fire && (differ || in_data_i.final_record);
    push_b   = in_fire && differ && in_data_i.final_record;
    data_a   = differ ? row0 : row1;
    push_n   = {1'b0, push_a} + {1'b0, push_b};
    wr_ptr_b = wr_ptr_q + QueuePtrW'(1);
    wr_ptr_d = wr_ptr_q + QueuePtrW'(push_n);
    rd_ptr_d = out_fire ? rd_ptr_q + QueuePtrW'(1) : rd_ptr_q;
    qcnt_d   = qcnt_q + QueueCntW'(push_n) - QueueCntW'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_count_q <= BankLim;
      cur_kmer_q   <= '0;
      open_q       <= 1'b0;
      mask_q       <= '0;
      sum_q        <= '0;
      cnt_q        <= '0;
      kept_q       <= '0;
      shared_q     <= '0;
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      qcnt_q       <= '0;
    end else begin
      if (cfg_we_i) bank_count_q <= cfg_data_i;
      cur_kmer_q <= cur_kmer_d;
      open_q     <= open_d;
      mask_q     <= mask_d;
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
      kept_q     <= kept_d;
      shared_q   <= shared_d;
      rd_ptr_q   <= rd_ptr_d;
      wr_ptr_q   <= wr_ptr_d;
      qcnt_q     <= qcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a) queue_q[wr_ptr_q] <= data_a;
    if (push_b) queue_q[wr_ptr_b] <= row1;
  end

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q <= QueueCntW'(QueueDepth))
    else $error("output queue over capacity");

  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.final_record) |=> (!open_q && mask_q == '0 && cnt_q == '0))
    else $error("group still open after final beat");

  a_kept_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> ($stable(kept_q) && $stable(shared_q)))
    else $error("totals moved without an input beat");

  a_row_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (differ || in_data_i.final_record) && !out_fire) |=> out_valid_o)
    else $error("row pushed but output not valid");

endmodule

FILE: dv/tb.sv
// Testbench for the k-mer group presence row block: predictor, checker and stimulus.
`timescale 1ns / 1ps

module tb
  import kgp_pkg::*;
();

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 6;

  class kmer_row_predictor;
    kgp_out_t             expected_rows[$];
    logic [KmerBits-1:0]  group_kmer;
    bit                   group_live;
    logic [MaxBanks-1:0]  group_mask;
    logic [1:0]           group_abund;
    logic [1:0]           group_records;
    logic [TotalBits-1:0] kept_count;
    logic [TotalBits-1:0] shared_count;
    logic [CfgBits-1:0]   bank_count;
    int                   mismatches;
    int                   rows_checked;

    function new();
      group_kmer    = '0;
      group_live    = 1'b0;
      group_mask    = '0;
      group_abund   = '0;
      group_records = '0;
      kept_count    = '0;
      shared_count  = '0;
      bank_count    = CfgBits'(64);
      mismatches    = 0;
      rows_checked  = 0;
    endfunction

    function void set_bank_count(logic [CfgBits-1:0] value);
      bank_count = value;
    endfunction

    function int pending_rows();
      return expected_rows.size();
    endfunction

    function void close_group(bit last);
      kgp_out_t row;
      bit       kept;
      bit       shared;
      kept   = group_abund > 2'd1;
      shared = group_records > 2'd1;
      if (kept && kept_count != '1) kept_count = kept_count + 1'b1;
      if (shared && shared_count != '1) shared_count = shared_count + 1'b1;
      row.row_kmer      = group_kmer;
      row.presence_mask = group_mask;
      row.row_kept      = kept;
      row.row_shared    = shared;
      row.kept_total    = kept_count;
      row.shared_total  = shared_count;
      row.row_last      = last;
      expected_rows = {expected_rows, row};
    endfunction

    function void note_record(kgp_in_t rec);
      int limit;
      if (group_live && rec.kmer_value != group_kmer) begin
        close_group(1'b0);
        group_live = 1'b0;
      end
      if (!group_live) begin
        group_kmer    = rec.kmer_value;
        group_live    = 1'b1;
        group_mask    = '0;
        group_abund   = '0;
        group_records = '0;
      end
      if (group_records < 2'd2) group_records = group_records + 1'b1;
      limit = (int'(bank_count) > MaxBanks) ? MaxBanks : int'(bank_count);
      // Out-of-range banks still count as records of the group.
      if (int'(rec.bank_index) < limit) begin
        if (rec.abundance_value != '0) group_mask[rec.bank_index] = 1'b1;
        if (rec.abundance_value >= 2) group_abund = 2'd2;
        else if (int'(group_abund) + int'(rec.abundance_value) >= 2) group_abund = 2'd2;
        else group_abund = group_abund + rec.abundance_value[1:0];
      end
      if (rec.final_record) begin
        close_group(1'b1);
        group_live    = 1'b0;
        group_mask    = '0;
        group_abund   = '0;
        group_records = '0;
      end
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR: row %0d %s: got %h, expected %h", rows_checked, what, got, want);
      mismatches++;
    endtask

    task check_row(kgp_out_t got);
      kgp_out_t want;
      rows_checked++;
      if (expected_rows.size() == 0) begin
        report("unexpected row, kmer", 64'(got.row_kmer), '0);
        return;
      end
      want = expected_rows.pop_front();
      if (got.row_kmer !== want.row_kmer)
        report("row_kmer", 64'(got.row_kmer), 64'(want.row_kmer));
      if (got.presence_mask !== want.presence_mask)
        report("presence_mask", got.presence_mask, want.presence_mask);
      if (got.row_kept !== want.row_kept)
        report("row_kept", 64'(got.row_kept), 64'(want.row_kept));
      if (got.row_shared !== want.row_shared)
        report("row_shared", 64'(got.row_shared), 64'(want.row_shared));
      if (got.kept_total !== want.kept_total)
        report("kept_total", 64'(got.kept_total), 64'(want.kept_total));
      if (got.shared_total !== want.shared_total)
        report("shared_total", 64'(got.shared_total), 64'(want.shared_total));
      if (got.row_last !== want.row_last)
        report("row_last", 64'(got.row_last), 64'(want.row_last));
    endtask
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  kgp_in_t            in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  kgp_out_t           out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [CfgBits-1:0] cfg_data_i  = '0;

  kmer_row_predictor   row_model = new();
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  cur_bank_count = 64;
  int                  cycle_count    = 0;
  logic [KmerBits-1:0] next_kmer      = '0;

  int phase_bank [7] = '{64, 0, 1, 127, 63, -1, -1};
  int phase_idle [7] = '{0, 69, 0, 24, 69, 0, 24};
  int phase_stall[7] = '{0, 0, 69, 24, 0, 69, 24};
  int phase_items[7] = '{250, 150, 150, 200, 150, 150, 250};

  kmer_group_presence_row DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) row_model.check_row(out_data_o);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic kgp_in_t make_record(logic [KmerBits-1:0] kmer, int bank,
                                          logic [AbundanceBits-1:0] abund, bit fin);
    kgp_in_t rec;
    rec.kmer_value      = kmer;
    rec.bank_index      = BankBits'(bank);
    rec.abundance_value = abund;
    rec.final_record    = fin;
    return rec;
  endfunction

  function automatic logic [AbundanceBits-1:0] random_abundance();
    case ($urandom_range(9))
      0, 1:    return '0;
      2, 3, 4: return AbundanceBits'(1);
      5, 6:    return AbundanceBits'($urandom_range(2, 9));
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_bank();
    int limit;
    limit = (cur_bank_count > MaxBanks) ? MaxBanks : cur_bank_count;
    if (limit > 0 && $urandom_range(9) < 8) return $urandom_range(0, limit - 1);
    return $urandom_range(0, 63);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_record(kgp_in_t rec);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= rec;
    do @(posedge clk_i); while (!in_ready_o);
    row_model.note_record(rec);
    @(negedge clk_i);
  endtask

  // Hold off intake until every predicted row has left the block.
  task automatic wait_rows_drained();
    in_valid_i <= 1'b0;
    while (row_model.pending_rows() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_bank_count(int value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= CfgBits'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    row_model.set_bank_count(CfgBits'(value));
    cur_bank_count = value;
    @(negedge clk_i);
  endtask

  task automatic advance_kmer();
    logic [63:0] r64;
    r64 = {$urandom, $urandom};
    case ($urandom_range(19))
      0:          next_kmer = r64[KmerBits-1:0];
      1, 2, 3, 4: next_kmer = next_kmer + KmerBits'($urandom_range(1, 1 << 20));
      default:    next_kmer = next_kmer + KmerBits'($urandom_range(1, 8));
    endcase
  endtask

  task automatic run_random_phase(int n_items);
    kgp_in_t     rec;
    logic [63:0] r64;
    int          sent;
    int          size;
    bit          paused;
    bit          ends_stream;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (!paused && sent >= n_items / 2) begin
        wait_rows_drained();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 15) begin
        // Noise: unsorted or repeated keys, any bank, stray final flags.
        r64 = {$urandom, $urandom};
        rec = make_record($urandom_range(1) ? r64[KmerBits-1:0]
                                            : next_kmer - KmerBits'($urandom_range(0, 3)),
                          $urandom_range(0, 63), random_abundance(),
                          $urandom_range(9) == 0);
        send_record(rec);
        sent++;
      end else begin
        advance_kmer();
        size        = $urandom_range(1, 4);
        ends_stream = ($urandom_range(11) == 0);
        for (int k = 0; k < size; k++) begin
          rec = make_record(next_kmer, pick_bank(), random_abundance(),
                            ends_stream && (k == size - 1));
          send_record(rec);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int bank_setting;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Extremes, joins, final with two rows, reopen after final, unsorted key.
    send_record(make_record('0, 0, '0, 1'b0));
    send_record(make_record('0, 63, 32'd1, 1'b0));
    send_record(make_record(62'd1, 5, 32'd1, 1'b0));
    send_record(make_record(62'd1, 6, 32'd1, 1'b0));
    send_record(make_record(62'd2, 7, 32'hFFFF_FFFF, 1'b1));
    send_record(make_record(62'd2, 8, 32'd2, 1'b0));
    send_record(make_record(62'd2, 9, 32'd0, 1'b1));
    send_record(make_record(62'h3FFF_FFFF_FFFF_FFFF, 63, 32'd3, 1'b0));
    send_record(make_record(62'd5, 1, 32'd1, 1'b0));
    send_record(make_record(62'd5, 1, 32'd1, 1'b0));
    send_record(make_record(62'd3, 2, 32'd0, 1'b1));
    send_record(make_record(62'h2AAA_AAAA_AAAA_AAAA, 42, 32'h5555_5555, 1'b0));
    send_record(make_record(62'h1555_5555_5555_5555, 21, 32'hAAAA_AAAA, 1'b1));
    send_record(make_record(62'd10, 0, 32'd0, 1'b1));
    wait_rows_drained();

    // Banks at and above the bank count add nothing to mask or sum.
    write_bank_count(2);
    send_record(make_record(62'd30, 1, 32'd1, 1'b0));
    send_record(make_record(62'd30, 2, 32'd5, 1'b0));
    send_record(make_record(62'd31, 63, 32'd7, 1'b0));
    send_record(make_record(62'd31, 0, 32'd1, 1'b1));
    wait_rows_drained();

    for (int p = 0; p < 7; p++) begin
      bank_setting = (phase_bank[p] < 0) ? $urandom_range(0, 127) : phase_bank[p];
      write_bank_count(bank_setting);
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      run_random_phase(phase_items[p]);
      wait_rows_drained();
    end

    repeat (10) @(posedge clk_i);
    if (row_model.pending_rows() != 0)
      row_model.report("rows never seen", 64'(row_model.pending_rows()), '0);
    if (row_model.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/kgp_pkg.sv
hdl/kmer_group_presence_row.sv
dv/tb.sv
